>>> hw/rtl/ts_pes_reassembly_control_defines.svh
// ----------------------------------------------------------------------------
// PES reassembly control: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TS_PES_REASSEMBLY_CONTROL_DEFINES_SVH
`define TS_PES_REASSEMBLY_CONTROL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold later than the antecedent.
`define TPR_ASSERT_LATER2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tpr_pkg.sv
// ----------------------------------------------------------------------------
// tpr_pkg
// Types and codes shared by the PES reassembly control block.
// ----------------------------------------------------------------------------
package tpr_pkg;

  localparam int PID_W        = 13;
  localparam int CC_W         = 4;
  localparam int SIZE_W       = 8;
  localparam int ACTION_W     = 3;
  localparam int OUT_INDEX_W  = 32;
  localparam int COUNT_W      = 32;
  localparam int PREFIX_BYTES = 3;

  localparam logic [ACTION_W-1:0] ACT_IGNORE    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_START     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_APPEND    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DUP       = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SYNC_LOST = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_SCRAMBLED = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_NOT_PES   = 3'd6;

  typedef struct packed {
    logic              sync_ok;
    logic [PID_W-1:0]  pid;
    logic              unit_start;
    logic [CC_W-1:0]   cont_counter;
    logic              scrambled;
    logic [SIZE_W-1:0] payload_size;
    logic [7:0]        byte_zero;
    logic [7:0]        byte_one;
    logic [7:0]        byte_two;
  } pkt_t;

  // Control part of one context entry.
  typedef struct packed {
    logic            valid;
    logic            sync;
    logic [CC_W-1:0] counter;
  } ctx_ctl_t;

  // What the packet does to its context and which records it causes.
  typedef struct packed {
    logic                emit_done;
    logic [ACTION_W-1:0] action;
    ctx_ctl_t            ctl;
    logic                set_first;
    logic                set_last;
    logic                clear_count;
  } decision_t;

endpackage

>>> hw/rtl/tpr_update.sv
// ----------------------------------------------------------------------------
// tpr_update
// Per-packet decision: next context control bits, index updates and action.
// ----------------------------------------------------------------------------
module tpr_update (
  input  tpr_pkg::pkt_t      pkt,
  input  tpr_pkg::ctx_ctl_t  ctx,
  output tpr_pkg::decision_t dec
);
  import tpr_pkg::*;

  logic take;
  logic is_pes;
  logic [CC_W-1:0] cc_next;

  assign take    = pkt.sync_ok && (ctx.valid || pkt.unit_start);
  assign is_pes  = (pkt.payload_size >= SIZE_W'(PREFIX_BYTES)) && (pkt.byte_zero == 8'h00)
                   && (pkt.byte_one == 8'h00) && (pkt.byte_two == 8'h01);
  assign cc_next = ctx.counter + CC_W'(1);

  always_comb begin
    dec             = '0;
    dec.ctl         = ctx;
    dec.action      = ACT_IGNORE;
    dec.emit_done   = take && ctx.valid && pkt.unit_start && ctx.sync;
    if (take) begin
      priority if (pkt.scrambled) begin
        dec.ctl.valid = 1'b0;
        dec.action    = ACT_SCRAMBLED;
      end else if (pkt.unit_start) begin
        if (is_pes) begin
          // A fresh context restarts its PES count; an existing one keeps it.
          dec.clear_count = !ctx.valid;
          dec.ctl.valid   = 1'b1;
          dec.ctl.sync    = 1'b1;
          dec.ctl.counter = pkt.cont_counter;
          dec.set_first   = 1'b1;
          dec.set_last    = 1'b1;
          dec.action      = ACT_START;
        end else begin
          dec.ctl.valid = 1'b0;
          dec.action    = ACT_NOT_PES;
        end
      end else if (ctx.valid && ctx.sync) begin
        priority if (pkt.cont_counter == ctx.counter) begin
          dec.action = ACT_DUP;
        end else if (pkt.cont_counter != cc_next) begin
          dec.ctl.sync = 1'b0;
          dec.action   = ACT_SYNC_LOST;
        end else begin
          dec.ctl.counter = pkt.cont_counter;
          dec.set_last    = 1'b1;
          dec.action      = ACT_APPEND;
        end
      end else begin
        // A continuation on an unsynchronized context is ignored.
        dec.action = ACT_IGNORE;
      end
    end
  end

endmodule

>>> hw/rtl/ts_pes_reassembly_control.sv
// ----------------------------------------------------------------------------
// ts_pes_reassembly_control
// Per-PID PES reassembly control over one synchronous context RAM.
// ----------------------------------------------------------------------------
// A packet header word is taken when start is high and busy is low. For each
// packet the context RAM is read in the accept cycle and written back in
// the next, and the action record appears on the out_ ports for one cycle,
// marked by out_strobe, right after. A unit start on a valid, synced context
// adds a completion record ahead of the action record. The receiver cannot
// stall, so every strobed word must be taken when it is shown. After reset
// the block clears the valid bits of all 8192 contexts, one per cycle, and
// holds busy high until the last one is written.
module ts_pes_reassembly_control #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_sync_ok,
  input  logic [12:0] in_pid,
  input  logic        in_unit_start,
  input  logic [3:0]  in_cont_counter,
  input  logic        in_scrambled,
  input  logic [7:0]  in_payload_size,
  input  logic [7:0]  in_byte_zero,
  input  logic [7:0]  in_byte_one,
  input  logic [7:0]  in_byte_two,
  output logic        out_strobe,
  output logic        out_kind,
  output logic [2:0]  out_action,
  output logic [12:0] out_pid,
  output logic [31:0] out_first_index,
  output logic [31:0] out_last_index,
  output logic [31:0] out_pes_total,
  output logic        out_last
);
  import tpr_pkg::*;

  localparam int DEPTH     = 1 << PID_W;
  localparam int FIRST_LSB = 2 + CC_W;
  localparam int LAST_LSB  = FIRST_LSB + INDEX_WIDTH;
  localparam int COUNT_LSB = LAST_LSB + INDEX_WIDTH;
  localparam int WORD_W    = COUNT_LSB + COUNT_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [WORD_W-1:0] ctx_mem [DEPTH];

  logic [1:0]             state_r, state_nxt;
  logic [PID_W-1:0]       clr_r, clr_nxt;
  logic [INDEX_WIDTH-1:0] idx_r, idx_nxt;
  pkt_t                   pkt_r;
  logic [WORD_W-1:0]      rd_r;
  logic [ACTION_W-1:0]    pend_r;

  logic accept;
  ctx_ctl_t rd_ctl;
  logic [INDEX_WIDTH-1:0] rd_first, rd_last, new_first, new_last;
  logic [COUNT_W-1:0]     rd_count, new_count;
  decision_t dec;
  logic              wr_en;
  logic [PID_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign rd_ctl   = rd_r[FIRST_LSB-1:0];
  assign rd_first = rd_r[FIRST_LSB +: INDEX_WIDTH];
  assign rd_last  = rd_r[LAST_LSB +: INDEX_WIDTH];
  assign rd_count = rd_r[COUNT_LSB +: COUNT_W];

  tpr_update u_update (
    .pkt (pkt_r),
    .ctx (rd_ctl),
    .dec (dec)
  );

  assign new_first = dec.set_first ? idx_r : rd_first;
  assign new_last  = dec.set_last ? idx_r : rd_last;
  always_comb begin
    new_count = rd_count + COUNT_W'(dec.emit_done);
    if (dec.clear_count) begin
      new_count = '0;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pkt_r.pid;
    wr_data = {new_count, new_last, new_first, dec.ctl};
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else if (state_r == ST_EXEC) begin
      wr_en = 1'b1;
    end
  end

  // Read and write never hit the same cycle for one packet: the write of
  // a packet lands before the next packet can be accepted.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ctx_mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_r <= ctx_mem[in_pid];
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + PID_W'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        idx_nxt   = idx_r + INDEX_WIDTH'(1);
        state_nxt = dec.emit_done ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      idx_r      <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      idx_r      <= idx_nxt;
      out_strobe <= (state_r == ST_EXEC) || (state_r == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pkt_r <= '{sync_ok: in_sync_ok, pid: in_pid, unit_start: in_unit_start,
                 cont_counter: in_cont_counter, scrambled: in_scrambled,
                 payload_size: in_payload_size, byte_zero: in_byte_zero,
                 byte_one: in_byte_one, byte_two: in_byte_two};
    end
    if (state_r == ST_EXEC) begin
      pend_r  <= dec.action;
      out_pid <= pkt_r.pid;
      if (dec.emit_done) begin
        out_kind        <= 1'b1;
        out_action      <= ACT_IGNORE;
        out_first_index <= OUT_INDEX_W'(rd_first);
        out_last_index  <= OUT_INDEX_W'(rd_last);
        out_pes_total   <= new_count;
        out_last        <= 1'b0;
      end else begin
        out_kind        <= 1'b0;
        out_action      <= dec.action;
        out_first_index <= '0;
        out_last_index  <= '0;
        out_pes_total   <= '0;
        out_last        <= 1'b1;
      end
    end else if (state_r == ST_EMIT) begin
      out_kind        <= 1'b0;
      out_action      <= pend_r;
      out_first_index <= '0;
      out_last_index  <= '0;
      out_pes_total   <= '0;
      out_last        <= 1'b1;
    end
  end

endmodule

>>> hw/rtl/tpr_checker.sv
// ----------------------------------------------------------------------------
// tpr_checker
// Port-level checks of record ordering and handshake timing.
// ----------------------------------------------------------------------------
`include "ts_pes_reassembly_control_defines.svh"

module tpr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic       out_kind,
  input logic [2:0] out_action,
  input logic       out_last
);
  import tpr_pkg::*;

  // A completion record is always followed at once by its action record.
  `TPR_ASSERT_NEXT(a_done_then_action, out_strobe && !out_last, out_strobe && out_last,
                   "completion record not followed by action record")
  // Completion records carry no action and are never the final word.
  `TPR_ASSERT_SAME(a_done_fields, out_strobe && out_kind,
                   !out_last && (out_action == ACT_IGNORE), "bad completion record fields")
  // Action records always close the packet.
  `TPR_ASSERT_SAME(a_action_last, out_strobe && !out_kind, out_last,
                   "action record without last")
  // An accepted packet holds the block busy and later yields a word.
  `TPR_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy && !out_strobe,
                   "busy or strobe wrong after accept")
  `TPR_ASSERT_LATER2(a_word_after_accept, start && !busy, out_strobe,
                     "no word two cycles after accept")

endmodule

bind ts_pes_reassembly_control tpr_checker u_tpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_kind   (out_kind),
  .out_action (out_action),
  .out_last   (out_last)
);
